// File: hw/rtl/u2t_pkg.sv
// shared types, format codes and helpers for the number-to-text converter
package u2t_pkg;

    localparam int NumChars    = 8;
    localparam int DabbleSteps = 16;
    localparam int BcdDigits   = 5;
    localparam int BcdWidth    = 4 * BcdDigits;

    localparam logic [2:0] CmdHex8  = 3'd0;
    localparam logic [2:0] CmdHex16 = 3'd1;
    localparam logic [2:0] CmdHex32 = 3'd2;
    localparam logic [2:0] CmdDec8  = 3'd3;
    localparam logic [2:0] CmdDec16 = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [7:0]  buffer_size;
    } req_t;

    typedef struct packed {
        logic [7:0] char_0;
        logic [7:0] char_1;
        logic [7:0] char_2;
        logic [7:0] char_3;
        logic [7:0] char_4;
        logic [7:0] char_5;
        logic [7:0] char_6;
        logic [7:0] char_7;
        logic [3:0] length;
    } res_t;

    typedef struct packed {
        logic [2:0]            cmd;
        logic [31:0]           value;
        logic [3:0]            room;
        logic [BcdWidth-1:0]   bcd;
        logic [DabbleSteps-1:0] bits;
    } work_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = 8'h30 + {4'd0, d};
        end
        else
        begin
            c = 8'h57 + {4'd0, d};
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/u2t_cell.sv
// one shift-and-add-3 step of the binary to bcd chain, with its own stage register
module u2t_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  u2t_pkg::work_t  in_data,
    input  logic            hold_in,
    output logic            out_valid,
    output u2t_pkg::work_t  out_data,
    output logic            hold_out
);

    logic           valid_reg;
    logic           valid_next;
    u2t_pkg::work_t data_reg;
    u2t_pkg::work_t data_next;
    logic [u2t_pkg::BcdWidth-1:0] fixed;

    assign hold_out  = valid_reg & hold_in;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        for (int n = 0; n < u2t_pkg::BcdDigits; n++)
        begin
            if (in_data.bcd[4*n +: 4] >= 4'd5)
            begin
                fixed[4*n +: 4] = in_data.bcd[4*n +: 4] + 4'd3;
            end
            else
            begin
                fixed[4*n +: 4] = in_data.bcd[4*n +: 4];
            end
        end
        data_next      = in_data;
        data_next.bcd  = {fixed[u2t_pkg::BcdWidth-2:0],
                          in_data.bits[u2t_pkg::DabbleSteps-1]};
        data_next.bits = {in_data.bits[u2t_pkg::DabbleSteps-2:0], 1'b0};
        valid_next     = hold_out ? valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_out && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/u2t_format.sv
// digit count, truncation to the buffer and ascii output register
module u2t_format (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  u2t_pkg::work_t  in_data,
    input  logic            stall,
    output logic            out_valid,
    output u2t_pkg::res_t   out_data,
    output logic            hold_out
);

    logic          valid_reg;
    logic          valid_next;
    u2t_pkg::res_t data_reg;
    u2t_pkg::res_t data_next;
    logic [31:0]   src;
    logic [3:0]    nibbles;
    logic          fmt_ok;
    logic [3:0]    wide;
    logic [3:0]    len;
    logic [2:0]    idx;
    logic [7:0]    chars [u2t_pkg::NumChars];

    assign hold_out  = valid_reg & stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        fmt_ok  = 1'b1;
        src     = in_data.value;
        nibbles = 4'd8;
        unique case (in_data.cmd)
            u2t_pkg::CmdHex8:
            begin
                src     = {24'd0, in_data.value[7:0]};
                nibbles = 4'd2;
            end
            u2t_pkg::CmdHex16:
            begin
                src     = {16'd0, in_data.value[15:0]};
                nibbles = 4'd4;
            end
            u2t_pkg::CmdHex32:
            begin
                src     = in_data.value;
                nibbles = 4'd8;
            end
            u2t_pkg::CmdDec8:
            begin
                src     = {{(32-u2t_pkg::BcdWidth){1'b0}}, in_data.bcd};
                nibbles = 4'd4;
            end
            u2t_pkg::CmdDec16:
            begin
                src     = {{(32-u2t_pkg::BcdWidth){1'b0}}, in_data.bcd};
                nibbles = 4'd8;
            end
            default:
            begin
                fmt_ok  = 1'b0;
                src     = 32'd0;
                nibbles = 4'd0;
            end
        endcase

        // count of significant nibbles, at least one
        wide = 4'd1;
        for (int i = 1; i < u2t_pkg::NumChars; i++)
        begin
            if (4'(i) < nibbles && src[4*i +: 4] != 4'd0)
            begin
                wide = 4'(i + 1);
            end
        end

        len = (wide > in_data.room) ? in_data.room : wide;
        if (!fmt_ok)
        begin
            len = 4'd0;
        end

        for (int i = 0; i < u2t_pkg::NumChars; i++)
        begin
            idx = 3'(len - 4'(i) - 4'd1);
            if (4'(i) < len)
            begin
                chars[i] = u2t_pkg::digit_char(src[4*idx +: 4]);
            end
            else
            begin
                chars[i] = 8'd0;
            end
        end

        data_next.char_0 = chars[0];
        data_next.char_1 = chars[1];
        data_next.char_2 = chars[2];
        data_next.char_3 = chars[3];
        data_next.char_4 = chars[4];
        data_next.char_5 = chars[5];
        data_next.char_6 = chars[6];
        data_next.char_7 = chars[7];
        data_next.length = len;
        valid_next       = hold_out ? valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_out && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/uint_to_hex_or_decimal_text_top.sv
// top level of the unsigned number to hex or decimal ascii text converter
//
// a request carries a format code, a 32-bit value and a buffer size; the
// response carries eight ascii characters, most significant first, and a
// character count. both channels use valid and stall: an item moves on a
// rising edge with valid high and stall low.
// a request passes a chain of 16 shift-and-add-3 cells (one bcd step each,
// used by the decimal formats and simply carried along by the hex ones) and
// then the formatting stage, which is the response register. one request
// can be accepted every cycle while req_stall is low.
// each stage moves on whenever the stage after it is empty or moving, so
// empty slots in the chain are squeezed out while the receiver stalls;
// req_stall rises only once every stage holds an item.
// reset clears all stage valid bits; no response is pending afterwards.
module uint_to_hex_or_decimal_text_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  u2t_pkg::req_t  req,
    output logic           res_valid,
    input  logic           res_stall,
    output u2t_pkg::res_t  res
);

    localparam int Steps = u2t_pkg::DabbleSteps;

    u2t_pkg::work_t stage_data [Steps+1];
    logic           stage_valid [Steps+1];
    logic           stage_hold [Steps+1];
    u2t_pkg::work_t entry;

    always_comb
    begin
        entry.cmd   = req.cmd;
        entry.value = req.value;
        entry.room  = (req.buffer_size >= 8'd8) ? 4'd8 : req.buffer_size[3:0];
        entry.bcd   = '0;
        // dec8 runs through eight leading zero steps first
        if (req.cmd == u2t_pkg::CmdDec8)
        begin
            entry.bits = {8'd0, req.value[7:0]};
        end
        else
        begin
            entry.bits = req.value[15:0];
        end
    end

    assign stage_data[0]  = entry;
    assign stage_valid[0] = req_valid;
    assign req_stall      = stage_hold[0];

    for (genvar k = 0; k < Steps; k++)
    begin : g_cell
        u2t_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .hold_in   (stage_hold[k+1]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1]),
            .hold_out  (stage_hold[k])
        );
    end

    u2t_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[Steps]),
        .in_data   (stage_data[Steps]),
        .stall     (res_stall),
        .out_valid (res_valid),
        .out_data  (res),
        .hold_out  (stage_hold[Steps])
    );

endmodule

// File: hw/rtl/u2t_checker.sv
// port-level checks for the number-to-text converter, bound to the top level
module u2t_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input u2t_pkg::req_t req,
    input logic          res_valid,
    input logic          res_stall,
    input u2t_pkg::res_t res
);

    // stalled response holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled response changed");

    // stalled request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled request changed");

    a_first_char: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.length != 4'd0 |-> res.char_0 != 8'd0)
        else $error("first character missing");

    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.length <= 4'd7 |-> res.char_7 == 8'd0)
        else $error("unused character not zero");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.length == 4'd0 |-> res.char_0 == 8'd0)
        else $error("empty response carries a character");

endmodule

bind uint_to_hex_or_decimal_text_top u2t_checker u_u2t_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
